@@ rtl/tgp_pkg.sv @@
// tgp_pkg: shared types and constants of the turtle grid plotter
// depends on nothing; imported by tgp_step, tgp_floor, turtle_grid_plotter and the bench tb
`timescale 1ns / 1ps
`default_nettype none

package tgp_pkg;

   // grid geometry: positions are 5 bits wide and a row fits one 32-bit word
   localparam int GRID_SIZE = 32;
   localparam int GRID_MAX  = 32;
   localparam int GRID_N    = (GRID_SIZE > GRID_MAX) ? GRID_MAX :
                              ((GRID_SIZE < 2) ? 2 : GRID_SIZE);
   localparam int IDX_W     = 5;
   localparam int ROW_W     = 32;
   localparam int MEM_DEPTH = 1 << IDX_W;
   localparam int STEPS_W   = 8;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_N - 1);

   // command codes
   typedef enum logic [2:0] {
      OP_PEN_UP     = 3'd0,
      OP_PEN_DOWN   = 3'd1,
      OP_TURN_RIGHT = 3'd2,
      OP_TURN_LEFT  = 3'd3,
      OP_FORWARD    = 3'd4,
      OP_DUMP       = 3'd5,
      OP_STATUS     = 3'd6
   } op_type;

   // heading codes
   localparam logic [1:0] HEAD_UP    = 2'd0;
   localparam logic [1:0] HEAD_RIGHT = 2'd1;
   localparam logic [1:0] HEAD_DOWN  = 2'd2;
   localparam logic [1:0] HEAD_LEFT  = 2'd3;

   // turtle position
   typedef struct packed {
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
   } pos_type;

   // request to mark one cell of the floor
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mark_req_type;

endpackage

`default_nettype wire

@@ rtl/tgp_step.sv @@
// tgp_step: shared move unit, edge test and next position for one step
// depends on tgp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgp_step (
   input  tgp_pkg::pos_type  pos,
   input  logic [1:0]        heading,
   output logic              can_move,
   output tgp_pkg::pos_type  next_pos
);
   import tgp_pkg::*;

   // edge test and one-cell move in the current heading
   always_comb begin
      next_pos = pos;
      case (heading)
         HEAD_UP: begin
            can_move     = (pos.row != '0);
            next_pos.row = pos.row - IDX_W'(1);
         end
         HEAD_RIGHT: begin
            can_move     = (pos.col != LAST_IDX);
            next_pos.col = pos.col + IDX_W'(1);
         end
         HEAD_DOWN: begin
            can_move     = (pos.row != LAST_IDX);
            next_pos.row = pos.row + IDX_W'(1);
         end
         default: begin
            can_move     = (pos.col != '0);
            next_pos.col = pos.col - IDX_W'(1);
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/tgp_floor.sv @@
// tgp_floor: cell bitmap memory with per-row valid bits and a
// read-modify-write mark pipeline; depends on tgp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgp_floor (
   input  logic                          clock,
   input  logic                          reset,
   input  tgp_pkg::mark_req_type         mark,
   input  logic [tgp_pkg::IDX_W-1:0]     rd_row,
   output logic [tgp_pkg::ROW_W-1:0]     rd_bits
);
   import tgp_pkg::*;

   logic [ROW_W-1:0] mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] row_valid_ff;

   logic [ROW_W-1:0] rdata_ff;
   logic             rvalid_ff;

   // mark stage waiting for its row word
   logic             p_valid_ff;
   logic [IDX_W-1:0] p_row_ff;
   logic [IDX_W-1:0] p_col_ff;

   // previous write, forwarded when the same row comes back straight away
   logic             lw_valid_ff;
   logic [IDX_W-1:0] lw_row_ff;
   logic [ROW_W-1:0] lw_data_ff;

   logic [IDX_W-1:0] raddr;
   logic [ROW_W-1:0] merged;
   logic [ROW_W-1:0] wdata;

   // marks take the read port ahead of dump reads
   assign raddr = mark.valid ? mark.row : rd_row;

   // old row word, newest copy first; a row never written reads as clear
   always_comb begin
      if (lw_valid_ff && (lw_row_ff == p_row_ff)) begin
         merged = lw_data_ff;
      end else if (rvalid_ff) begin
         merged = rdata_ff;
      end else begin
         merged = '0;
      end
      wdata = merged | (ROW_W'(1) << p_col_ff);
   end

   assign rd_bits = rvalid_ff ? rdata_ff : '0;

   // memory array: one read and one write a cycle
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (p_valid_ff) begin
         mem[p_row_ff] <= wdata;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      p_row_ff   <= mark.row;
      p_col_ff   <= mark.col;
      lw_row_ff  <= p_row_ff;
      lw_data_ff <= wdata;
   end

   // control state and row valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
         p_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         rvalid_ff   <= row_valid_ff[raddr];
         p_valid_ff  <= mark.valid;
         lw_valid_ff <= p_valid_ff;
         if (p_valid_ff) begin
            row_valid_ff[p_row_ff] <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/turtle_grid_plotter.sv @@
// turtle_grid_plotter: a pen turtle on a 32 by 32 cell bitmap
// simple commands: strobe registered from ST_REPLY after accept; forward: ST_WALK for k steps
// taken (k up to 31), one cell a cycle through the shared move unit, then ST_REPLY
// dump: 32 row items on consecutive cycles, the first through ST_DUMP, the row read and pend_ff
// one command at a time, next accept in the cycle its final item shows; no receiver stall
// synchronous reset clears the floor (row valid bits), position, heading right, pen up
`timescale 1ns / 1ps
`default_nettype none

module turtle_grid_plotter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_operation,
   input  logic [tgp_pkg::STEPS_W-1:0]   req_steps,
   output logic                          rsp_strobe,
   output logic [tgp_pkg::IDX_W-1:0]     rsp_row_index,
   output logic [tgp_pkg::ROW_W-1:0]     rsp_row_bits,
   output logic [tgp_pkg::IDX_W-1:0]     rsp_pos_col,
   output logic [tgp_pkg::IDX_W-1:0]     rsp_pos_row,
   output logic [1:0]                    rsp_heading,
   output logic                          rsp_pen_down,
   output logic                          rsp_last
);
   import tgp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPLY,
      ST_DUMP,
      ST_DUMP_TAIL
   } state_type;

   state_type          state_ff;
   pos_type            pos_ff;
   logic [1:0]         head_ff;
   logic               pen_ff;
   logic [STEPS_W-1:0] steps_ff;
   logic [IDX_W-1:0]   cnt_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_row_ff;

   logic               strobe_ff;
   logic [IDX_W-1:0]   out_row_index_ff;
   logic [ROW_W-1:0]   out_row_bits_ff;
   logic               out_last_ff;

   logic               can_move;
   pos_type            next_pos;
   mark_req_type       mark;
   logic [ROW_W-1:0]   rd_bits;
   logic               accept;
   op_type             op;

   assign accept = start && (state_ff == ST_IDLE);
   assign op     = op_type'(req_operation);
   assign busy   = (state_ff != ST_IDLE);

   // shared move unit
   tgp_step u_step (
      .pos      (pos_ff),
      .heading  (head_ff),
      .can_move (can_move),
      .next_pos (next_pos)
   );

   // mark the current cell on pen down, and on every walk cycle with the pen down
   always_comb begin
      mark.valid = (accept && (op == OP_PEN_DOWN)) ||
                   ((state_ff == ST_WALK) && pen_ff);
      mark.row   = pos_ff.row;
      mark.col   = pos_ff.col;
   end

   tgp_floor u_floor (
      .clock   (clock),
      .reset   (reset),
      .mark    (mark),
      .rd_row  (cnt_ff),
      .rd_bits (rd_bits)
   );

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pos_ff           <= '0;
         head_ff          <= HEAD_RIGHT;
         pen_ff           <= 1'b0;
         steps_ff         <= '0;
         cnt_ff           <= '0;
         pend_ff          <= 1'b0;
         pend_row_ff      <= '0;
         strobe_ff        <= 1'b0;
         out_row_index_ff <= '0;
         out_row_bits_ff  <= '0;
         out_last_ff      <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;

         // dump row read last cycle becomes a result item
         if (pend_ff) begin
            strobe_ff        <= 1'b1;
            out_row_index_ff <= pend_row_ff;
            out_row_bits_ff  <= rd_bits;
            out_last_ff      <= (pend_row_ff == LAST_IDX);
         end

         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_REPLY;
                  case (op)
                     OP_PEN_UP:     pen_ff  <= 1'b0;
                     OP_PEN_DOWN:   pen_ff  <= 1'b1;
                     OP_TURN_RIGHT: head_ff <= head_ff + 2'd1;
                     OP_TURN_LEFT:  head_ff <= head_ff - 2'd1;
                     OP_FORWARD: begin
                        steps_ff <= req_steps;
                        state_ff <= ST_WALK;
                     end
                     OP_DUMP: begin
                        cnt_ff   <= '0;
                        state_ff <= ST_DUMP;
                     end
                     default: ;
                  endcase
               end
            end
            ST_WALK: begin
               if ((steps_ff != '0) && can_move) begin
                  pos_ff   <= next_pos;
                  steps_ff <= steps_ff - STEPS_W'(1);
               end else begin
                  state_ff <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               strobe_ff        <= 1'b1;
               out_row_index_ff <= '0;
               out_row_bits_ff  <= '0;
               out_last_ff      <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            ST_DUMP: begin
               pend_ff     <= 1'b1;
               pend_row_ff <= cnt_ff;
               cnt_ff      <= cnt_ff + IDX_W'(1);
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_DUMP_TAIL;
               end
            end
            ST_DUMP_TAIL: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_row_index = out_row_index_ff;
   assign rsp_row_bits  = out_row_bits_ff;
   assign rsp_pos_col   = pos_ff.col;
   assign rsp_pos_row   = pos_ff.row;
   assign rsp_heading   = head_ff;
   assign rsp_pen_down  = pen_ff;
   assign rsp_last      = out_last_ff;

   // every accepted item makes the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // dump rows come on consecutive cycles up to the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a dump");

   // the final item of a command is never directly followed by another
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result item right after a final item");

   // no cell marking while the grid is being read out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) || (state_ff == ST_DUMP_TAIL) |-> !mark.valid)
      else $error("mark during dump");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for turtle_grid_plotter, directed moves then random traffic
// keeps its own copy of the turtle and the floor; depends on rtl/tgp_pkg.sv and the rtl top
`timescale 1ns / 1ps

module tb;
   import tgp_pkg::*;

   // code with no command behind it, handled as status by the block
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic [ROW_W-1:0] row_bits;
      logic [IDX_W-1:0] pos_col;
      logic [IDX_W-1:0] pos_row;
      logic [1:0]       heading;
      logic             pen_down;
      logic             last;
   } plot_report_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [2:0]           req_operation;
   logic [STEPS_W-1:0]   req_steps;
   logic                 rsp_strobe;
   logic [IDX_W-1:0]     rsp_row_index;
   logic [ROW_W-1:0]     rsp_row_bits;
   logic [IDX_W-1:0]     rsp_pos_col;
   logic [IDX_W-1:0]     rsp_pos_row;
   logic [1:0]           rsp_heading;
   logic                 rsp_pen_down;
   logic                 rsp_last;

   // shadow of the turtle and the floor
   logic [ROW_W-1:0]     floor_map [GRID_MAX];
   logic [IDX_W-1:0]     turtle_col;
   logic [IDX_W-1:0]     turtle_row;
   logic [1:0]           turtle_head;
   logic                 turtle_pen;

   plot_report_type      awaited_reports [$];
   int                   err_count    = 0;
   int                   items_sent   = 0;
   int                   reports_seen = 0;
   int                   quiet_cycles = 0;

   turtle_grid_plotter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_steps     (req_steps),
      .rsp_strobe    (rsp_strobe),
      .rsp_row_index (rsp_row_index),
      .rsp_row_bits  (rsp_row_bits),
      .rsp_pos_col   (rsp_pos_col),
      .rsp_pos_row   (rsp_pos_row),
      .rsp_heading   (rsp_heading),
      .rsp_pen_down  (rsp_pen_down),
      .rsp_last      (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function void mark_cell();
      floor_map[turtle_row] = floor_map[turtle_row] | (32'd1 << turtle_col);
   endfunction

   function void queue_report(input logic [IDX_W-1:0] ri, input logic [ROW_W-1:0] bits,
                              input logic is_last);
      plot_report_type rep;
      rep.row_index = ri;
      rep.row_bits  = bits;
      rep.pos_col   = turtle_col;
      rep.pos_row   = turtle_row;
      rep.heading   = turtle_head;
      rep.pen_down  = turtle_pen;
      rep.last      = is_last;
      awaited_reports.push_back(rep);
   endfunction

   // apply one accepted command to the shadow and queue what it should report
   task automatic predict_plot(input logic [2:0] op, input logic [STEPS_W-1:0] n);
      int  i;
      logic can_move;
      logic stopped;
      case (op)
         OP_PEN_UP: begin
            turtle_pen = 1'b0;
         end
         OP_PEN_DOWN: begin
            turtle_pen = 1'b1;
            mark_cell();
         end
         OP_TURN_RIGHT: begin
            turtle_head = turtle_head + 2'd1;
         end
         OP_TURN_LEFT: begin
            turtle_head = turtle_head + 2'd3;
         end
         OP_FORWARD: begin
            // step until the count runs out or the edge is hit
            stopped = 1'b0;
            for (i = 0; i < n; i++) begin
               if (!stopped) begin
                  case (turtle_head)
                     HEAD_UP:    can_move = (turtle_row >= 1);
                     HEAD_RIGHT: can_move = (turtle_col < GRID_N - 1);
                     HEAD_DOWN:  can_move = (turtle_row < GRID_N - 1);
                     default:    can_move = (turtle_col >= 1);
                  endcase
                  if (!can_move) begin
                     stopped = 1'b1;
                  end else begin
                     if (turtle_pen) mark_cell();
                     case (turtle_head)
                        HEAD_UP:    turtle_row = turtle_row - 1'b1;
                        HEAD_RIGHT: turtle_col = turtle_col + 1'b1;
                        HEAD_DOWN:  turtle_row = turtle_row + 1'b1;
                        default:    turtle_col = turtle_col - 1'b1;
                     endcase
                  end
               end
            end
            if (turtle_pen) mark_cell();
         end
         default: begin
         end
      endcase
      if (op == OP_DUMP) begin
         for (i = 0; i < GRID_N; i++)
            queue_report(IDX_W'(i), floor_map[i], i == GRID_N - 1);
      end else begin
         queue_report('0, '0, 1'b1);
      end
   endtask

   function void check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         err_count++;
      end
   endfunction

   // result checker: every strobe against the oldest awaited report
   always @(posedge clock) begin
      plot_report_type want;
      if (!reset && rsp_strobe) begin
         reports_seen++;
         if (awaited_reports.size() == 0) begin
            $error("unexpected result: row_index %0d row_bits %0h",
                   rsp_row_index, rsp_row_bits);
            err_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("row_index", want.row_index, rsp_row_index);
            check_field("row_bits",  want.row_bits,  rsp_row_bits);
            check_field("pos_col",   want.pos_col,   rsp_pos_col);
            check_field("pos_row",   want.pos_row,   rsp_pos_row);
            check_field("heading",   want.heading,   rsp_heading);
            check_field("pen_down",  want.pen_down,  rsp_pen_down);
            check_field("last",      want.last,      rsp_last);
         end
      end
   end

   // watchdog: too long with neither an item nor a result moving
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, awaited_reports.size());
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one item and hold it until the block takes it
   task automatic send_item(input logic [2:0] op, input logic [STEPS_W-1:0] n);
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_steps     <= n;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_plot(op, n);
      items_sent++;
   endtask

   // random sender gap before the next item
   task automatic hold_off(input int pct);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending until every awaited report is in
   task automatic wait_for_reports();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // status and dump straight after reset
   task automatic test_after_reset();
      send_item(OP_STATUS, 8'd0);
      send_item(OP_DUMP, 8'd255);
   endtask

   // drawing, every turn, zero steps and the right, top and bottom grid edges
   task automatic test_moves_and_edges();
      send_item(OP_PEN_DOWN, 8'd0);
      send_item(OP_FORWARD, 8'd0);
      send_item(OP_FORWARD, 8'd255);
      send_item(OP_FORWARD, 8'd1);
      send_item(OP_TURN_RIGHT, 8'd0);
      send_item(OP_FORWARD, 8'd7);
      send_item(OP_TURN_RIGHT, 8'd0);
      send_item(OP_FORWARD, 8'd3);
      send_item(OP_TURN_RIGHT, 8'd0);
      send_item(OP_FORWARD, 8'd255);
      send_item(OP_TURN_LEFT, 8'd0);
      send_item(OP_TURN_LEFT, 8'd0);
      send_item(OP_PEN_UP, 8'd85);
      send_item(OP_FORWARD, 8'd128);
      send_item(OP_TURN_LEFT, 8'd0);
      send_item(OP_FORWARD, 8'd2);
      send_item(OP_UNUSED, 8'd170);
      send_item(OP_PEN_DOWN, 8'd0);
      send_item(OP_TURN_RIGHT, 8'd0);
      send_item(OP_FORWARD, 8'd1);
      send_item(OP_STATUS, 8'd0);
      send_item(OP_DUMP, 8'd0);
   endtask

   // mostly drawing moves with random content, a little noise
   task automatic test_random_traffic(input int count, input int idle_pct);
      int k;
      int pick;
      logic [2:0] op;
      logic [STEPS_W-1:0] n;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if      (pick < 40) op = OP_FORWARD;
         else if (pick < 55) op = OP_TURN_RIGHT;
         else if (pick < 70) op = OP_TURN_LEFT;
         else if (pick < 80) op = OP_PEN_DOWN;
         else if (pick < 88) op = OP_PEN_UP;
         else if (pick < 93) op = OP_STATUS;
         else if (pick < 97) op = OP_DUMP;
         else                op = OP_UNUSED;
         pick = $urandom_range(99);
         if      (pick < 70) n = STEPS_W'($urandom_range(0, 15));
         else if (pick < 90) n = STEPS_W'($urandom_range(0, 31));
         else                n = STEPS_W'($urandom_range(0, 255));
         hold_off(idle_pct);
         send_item(op, n);
      end
   endtask

   // a long stroke, then a pause until the block has gone quiet
   task automatic test_pause_until_idle();
      send_item(OP_PEN_DOWN, 8'd0);
      send_item(OP_FORWARD, 8'd31);
      send_item(OP_DUMP, 8'd0);
      wait_for_reports();
      send_item(OP_STATUS, 8'd0);
   endtask

   initial begin
      int r;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_PEN_UP;
      req_steps     = '0;
      for (r = 0; r < GRID_MAX; r++) floor_map[r] = '0;
      turtle_col  = '0;
      turtle_row  = '0;
      turtle_head = HEAD_RIGHT;
      turtle_pen  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_moves_and_edges();
      test_random_traffic(35, 33);
      test_pause_until_idle();
      test_random_traffic(35, 79);
      wait_for_reports();
      test_random_traffic(35, 0);

      // drain and let the block settle
      wait_for_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_reports.size() != 0) begin
         $error("%0d results never arrived", awaited_reports.size());
         err_count++;
      end

      $display("run: %0d commands (moves, turns, pen, status, dumps, unused code)",
               items_sent);
      $display("run: %0d results checked, %0d mismatches", reports_seen, err_count);
      if (err_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
